/* design/text_console_char_engine_defines.svh */
// ----------------------------------------------------------------------------
// text console char engine assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define TCCE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TCCE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// shared constants, command types and the tab stop table of the console
// ----------------------------------------------------------------------------
package tcce_pkg;

	localparam int ROWS     = 25;
	localparam int COLUMNS  = 80;
	localparam int TAB_STOP = 8;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int AW     = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int COLN_W = $clog2(COLUMNS + TAB_STOP);

	// fixed port widths
	localparam int CH_W       = 8;
	localparam int RROW_W     = 5;
	localparam int RCOL_W     = 7;
	localparam int CELL_W     = 16;
	localparam int OROW_W     = 5;
	localparam int OCOL_W     = 7;
	localparam int OPOS_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// command queue
	localparam int FQ_DEPTH = 2;
	localparam int FQ_PW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

	localparam logic OP_CHAR = 1'b0;

	localparam logic [CH_W-1:0] CH_BS       = 8'd8;
	localparam logic [CH_W-1:0] CH_TAB      = 8'd9;
	localparam logic [CH_W-1:0] CH_LF       = 8'd10;
	localparam logic [CH_W-1:0] CH_FF       = 8'd12;
	localparam logic [CH_W-1:0] CH_CR       = 8'd13;
	localparam logic [CH_W-1:0] CH_PRINT_LO = 8'd32;
	localparam logic [CH_W-1:0] CH_PRINT_HI = 8'd126;

	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd2;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_PRINT,
		CMD_BS,
		CMD_TAB,
		CMD_LF,
		CMD_FF,
		CMD_CR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CH_W-1:0]   ch;
		logic              rd_ok;
		logic [AW-1:0]     rd_addr;
	} cmd_t;

	typedef struct packed {
		logic [3:0] text_color;
		logic [2:0] back_color;
		logic       console_enable;
	} cfg_t;

	typedef logic [COLUMNS-1:0][COLN_W-1:0] tab_tbl_t;

	function automatic tab_tbl_t build_tab();
		tab_tbl_t t;
		for (int c = 0; c < COLUMNS; c++) begin
			t[c] = COLN_W'((c / TAB_STOP + 1) * TAB_STOP);
		end
		return t;
	endfunction

	localparam tab_tbl_t TAB_NEXT = build_tab();

endpackage

/* design/tcce_front.sv */
// ----------------------------------------------------------------------------
// tcce_front
// takes input beats and sorts them into commands for the back end
// ----------------------------------------------------------------------------
module tcce_front (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [tcce_pkg::CH_W-1:0]    char_byte,
	input  logic [tcce_pkg::RROW_W-1:0]  read_row,
	input  logic [tcce_pkg::RCOL_W-1:0]  read_col,
	input  logic                         fifo_full,
	output logic                         push,
	output tcce_pkg::cmd_t               cmd
);
	import tcce_pkg::*;

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		cmd      = '0;
		cmd.kind = CMD_NOP;
		cmd.ch   = char_byte;
		if (operation == OP_CHAR) begin
			case (char_byte)
				CH_BS:   cmd.kind = CMD_BS;
				CH_TAB:  cmd.kind = CMD_TAB;
				CH_LF:   cmd.kind = CMD_LF;
				CH_FF:   cmd.kind = CMD_FF;
				CH_CR:   cmd.kind = CMD_CR;
				default: begin
					if (char_byte inside {[CH_PRINT_LO:CH_PRINT_HI]})
						cmd.kind = CMD_PRINT;
				end
			endcase
		end else begin
			cmd.kind    = CMD_READ;
			cmd.rd_ok   = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
			cmd.rd_addr = AW'(int'(read_row) * COLUMNS + int'(read_col));
		end
	end

endmodule

/* design/tcce_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// tcce_cmd_fifo
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`include "text_console_char_engine_defines.svh"

module tcce_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcce_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output tcce_pkg::cmd_t  pop_cmd,
	output logic            not_empty
);
	import tcce_pkg::*;

	cmd_t             fifo_q [FQ_DEPTH];
	logic [FQ_PW-1:0] wr_ptr_q;
	logic [FQ_PW-1:0] rd_ptr_q;
	logic [FQ_CW-1:0] count_q;

	assign full      = (count_q == FQ_CW'(FQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FQ_PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FQ_PW'(1);
			if (push && !pop)
				count_q <= count_q + FQ_CW'(1);
			else if (pop && !push)
				count_q <= count_q - FQ_CW'(1);
		end
	end

	`TCCE_ASSERT_NEXT(a_pop_drains, pop && !push, count_q == $past(count_q) - FQ_CW'(1), "fifo count did not drop on pop")

endmodule

/* design/tcce_back.sv */
// ----------------------------------------------------------------------------
// tcce_back
// executes commands: cursor, screen store, scroll and clear passes, result
// ----------------------------------------------------------------------------
`include "text_console_char_engine_defines.svh"

module tcce_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcce_pkg::cfg_t               cfg,
	input  logic                         fifo_valid,
	input  tcce_pkg::cmd_t               fifo_cmd,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tcce_pkg::CELL_W-1:0]  cell_data,
	output logic [tcce_pkg::OROW_W-1:0]  cursor_row,
	output logic [tcce_pkg::OCOL_W-1:0]  cursor_col,
	output logic [tcce_pkg::OPOS_W-1:0]  cursor_position
);
	import tcce_pkg::*;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_READ   = 7'b0000100,
		S_FILL   = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_BLANK  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);

	state_t             state_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [AW-1:0]      pass_q;
	logic               rd_ok_q;
	logic               cp_vld_s1;
	logic [AW-1:0]      cp_dst_s1;
	logic [CELL_W-1:0]  rdata_q;
	logic [CELL_W-1:0]  cells_mem [CELLS];

	logic               out_valid_q;
	logic [CELL_W-1:0]  out_cell_q;
	logic [OROW_W-1:0]  out_row_q;
	logic [OCOL_W-1:0]  out_col_q;
	logic [OPOS_W-1:0]  out_pos_q;

	logic [COLN_W-1:0]  coln;
	logic               eol;
	logic [ROW_W-1:0]   row_nx;
	logic [COL_W-1:0]   col_nx;
	logic               need_scroll;
	logic               need_fill;
	logic               out_free;
	logic               ld;
	logic [ROW_W-1:0]   ld_row;
	logic [COL_W-1:0]   ld_col;
	logic [CELL_W-1:0]  ld_cell;
	logic [7:0]         attr;
	logic [AW-1:0]      cur_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [CELL_W-1:0]  mem_wd;
	logic [AW-1:0]      mem_ra;

	assign attr     = {1'b0, cfg.back_color, cfg.text_color};
	assign cur_addr = AW'(int'(row_q) * COLUMNS + int'(col_q));
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == S_IDLE) && fifo_valid && out_free;

	// next cursor for the command at the head of the queue
	always_comb begin
		coln        = COLN_W'(col_q);
		eol         = 1'b0;
		row_nx      = row_q;
		col_nx      = col_q;
		need_scroll = 1'b0;
		need_fill   = 1'b0;
		case (fifo_cmd.kind)
			CMD_PRINT: coln = COLN_W'(col_q) + COLN_W'(1);
			CMD_BS: begin
				if (col_q != '0)
					coln = COLN_W'(col_q) - COLN_W'(1);
			end
			CMD_TAB:   coln = TAB_NEXT[col_q];
			CMD_LF:    eol = 1'b1;
			CMD_CR:    coln = '0;
			CMD_FF:    coln = '0;
			default:   ;
		endcase
		if (coln >= COLN_W'(COLUMNS))
			eol = 1'b1;
		if (eol) begin
			col_nx = '0;
			if (int'(row_q) >= ROWS - 1)
				need_scroll = 1'b1;
			else
				row_nx = row_q + ROW_W'(1);
		end else begin
			col_nx = COL_W'(coln);
		end
		if (fifo_cmd.kind == CMD_FF) begin
			row_nx    = '0;
			col_nx    = '0;
			need_fill = cfg.console_enable;
		end
	end

	// screen store ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pass_q;
		mem_wd = '0;
		case (state_q)
			S_INIT: mem_we = 1'b1;
			S_FILL, S_BLANK: begin
				mem_we = 1'b1;
				mem_wd = {attr, 8'h00};
			end
			S_IDLE: begin
				mem_we = pop && (fifo_cmd.kind == CMD_PRINT) && cfg.console_enable;
				mem_wa = cur_addr;
				mem_wd = {attr, fifo_cmd.ch};
			end
			default: ;
		endcase
		if (cp_vld_s1) begin
			mem_we = 1'b1;
			mem_wa = cp_dst_s1;
			mem_wd = rdata_q;
		end
		if (state_q == S_SCROLL)
			mem_ra = pass_q + AW'(COLUMNS);
		else
			mem_ra = fifo_cmd.rd_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			cells_mem[mem_wa] <= mem_wd;
		rdata_q <= cells_mem[mem_ra];
	end

	// result load
	always_comb begin
		ld = 1'b0;
		case (state_q)
			S_IDLE: ld = pop && (fifo_cmd.kind != CMD_READ) && !need_fill && !need_scroll;
			S_READ: ld = 1'b1;
			S_DONE: ld = out_free;
			default: ;
		endcase
		ld_row  = (state_q == S_IDLE) ? row_nx : row_q;
		ld_col  = (state_q == S_IDLE) ? col_nx : col_q;
		ld_cell = ((state_q == S_READ) && rd_ok_q) ? rdata_q : '0;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_cell_q <= ld_cell;
			out_row_q  <= OROW_W'(ld_row);
			out_col_q  <= OCOL_W'(ld_col);
			out_pos_q  <= OPOS_W'(int'(ld_row) * COLUMNS + int'(ld_col));
		end
		cp_dst_s1 <= pass_q;
		if (pop)
			rd_ok_q <= fifo_cmd.rd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pass_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			cp_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == S_SCROLL) && (pass_q != COPY_END);
			if (ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					if (pass_q == LAST_CELL) begin
						pass_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						pass_q <= pass_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (pop) begin
						row_q  <= row_nx;
						col_q  <= col_nx;
						pass_q <= '0;
						if (fifo_cmd.kind == CMD_READ)
							state_q <= S_READ;
						else if (need_fill)
							state_q <= S_FILL;
						else if (need_scroll)
							state_q <= S_SCROLL;
					end
				end
				S_READ: state_q <= S_IDLE;
				S_FILL: begin
					if (pass_q == LAST_CELL)
						state_q <= S_DONE;
					else
						pass_q <= pass_q + AW'(1);
				end
				S_SCROLL: begin
					// last copy write drains here; with the console enabled, blanking starts on the bottom row
					if (pass_q == COPY_END)
						state_q <= cfg.console_enable ? S_BLANK : S_DONE;
					else
						pass_q <= pass_q + AW'(1);
				end
				S_BLANK: begin
					if (pass_q == LAST_CELL)
						state_q <= S_DONE;
					else
						pass_q <= pass_q + AW'(1);
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_data       = out_cell_q;
	assign cursor_row      = out_row_q;
	assign cursor_col      = out_col_q;
	assign cursor_position = out_pos_q;

	`TCCE_ASSERT_IMPLIES(a_read_slot_free, state_q == S_READ, !out_valid_q, "read result slot busy")
	`TCCE_ASSERT_IMPLIES(a_cursor_range, 1'b1, (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS), "cursor off screen")
	`TCCE_ASSERT_IMPLIES(a_copy_in_scroll, cp_vld_s1, state_q == S_SCROLL, "copy write outside scroll")

endmodule

/* design/text_console_char_engine.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine
// text console: screen store of attribute and character cells with a cursor
// ----------------------------------------------------------------------------
// After reset the engine clears every cell of the screen store; in that time it
// takes at most two input beats, which wait in its queue. Configuration writes
// are taken throughout. Input beats land in a two-entry command queue, so a beat
// can be taken every cycle while the queue has room. The back end loads the
// result of a printable character, a control byte or a cursor move on the pop,
// and that of a cell read from the read state, as the read port of the screen
// store is registered. A line end on the bottom row scrolls the whole store, one
// cell a cycle over the one write port: a copy pass, then a blanking pass of the
// bottom row if the console is enabled. A form feed with the console enabled
// fills every cell. Each input beat gives exactly one output beat.
module text_console_char_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [tcce_pkg::CH_W-1:0]        char_byte,
	input  logic [tcce_pkg::RROW_W-1:0]      read_row,
	input  logic [tcce_pkg::RCOL_W-1:0]      read_col,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tcce_pkg::CELL_W-1:0]      cell_data,
	output logic [tcce_pkg::OROW_W-1:0]      cursor_row,
	output logic [tcce_pkg::OCOL_W-1:0]      cursor_col,
	output logic [tcce_pkg::OPOS_W-1:0]      cursor_position
);
	import tcce_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	cmd_t  push_cmd;
	logic  fifo_full;
	logic  pop;
	cmd_t  pop_cmd;
	logic  fifo_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color     <= 4'hF;
			cfg_q.back_color     <= 3'h0;
			cfg_q.console_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEXT_COLOR: cfg_q.text_color     <= cfg_data[3:0];
				CFG_BACK_COLOR: cfg_q.back_color     <= cfg_data[2:0];
				CFG_ENABLE:     cfg_q.console_enable <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	tcce_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.char_byte (char_byte),
		.read_row  (read_row),
		.read_col  (read_col),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	tcce_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (fifo_valid)
	);

	tcce_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.fifo_valid      (fifo_valid),
		.fifo_cmd        (pop_cmd),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_data       (cell_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.cursor_position (cursor_position)
	);

endmodule

/* dv/text_console_char_engine_tb.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine_tb
// self-checking bench for the text console: character and read beats go in
// through the valid/stall port, and a shadow screen with cursor predicts each
// result beat, compared field by field as it leaves the block. Colour and
// enable settings change between phases, while both ports idle and stall at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_char_engine_tb;
	import tcce_pkg::*;

	localparam logic OP_READ = ~OP_CHAR;
	// slowest legal run: every beat a full-screen scroll plus gaps and stalls, taken four times over
	localparam int unsigned CYCLE_LIMIT = 12_000_000;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic              operation;
		logic [CH_W-1:0]   char_byte;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_col;
	} console_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [OROW_W-1:0] cursor_row;
		logic [OCOL_W-1:0] cursor_col;
		logic [OPOS_W-1:0] cursor_position;
	} console_beat_t;

	class console_checker;
		logic [CELL_W-1:0] cells [CELLS];
		int unsigned       row_at;
		int unsigned       col_at;
		logic [3:0]        fg;
		logic [2:0]        bg;
		logic              en;
		console_beat_t     cursor_cell_q[$];
		int unsigned       failures;
		int unsigned       beats_seen;
		int unsigned       scrolls;
		int unsigned       clears;
		int unsigned       reads;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			row_at = 0;
			col_at = 0;
			fg = 4'd15;
			bg = 3'd0;
			en = 1'b1;
			failures = 0;
			beats_seen = 0;
			scrolls = 0;
			clears = 0;
			reads = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TEXT_COLOR: fg = data[3:0];
				CFG_BACK_COLOR: bg = data[2:0];
				CFG_ENABLE:     en = data[0];
				default: ;
			endcase
		endfunction

		function logic [CELL_W-1:0] attr_cell(logic [CH_W-1:0] ch);
			return {1'b0, bg, fg, ch};
		endfunction

		function void put_cell(int unsigned r, int unsigned c, logic [CH_W-1:0] ch);
			if (en)
				cells[r * COLUMNS + c] = attr_cell(ch);
		endfunction

		function void scroll_screen();
			for (int i = 0; i < CELLS - COLUMNS; i++)
				cells[i] = cells[i + COLUMNS];
			for (int j = 0; j < COLUMNS; j++)
				put_cell(ROWS - 1, j, 8'd0);
			scrolls++;
		endfunction

		function void line_end();
			col_at = 0;
			if (row_at >= ROWS - 1)
				scroll_screen();
			else
				row_at++;
		endfunction

		function void apply_char(logic [CH_W-1:0] ch);
			if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
				put_cell(row_at, col_at, ch);
				col_at++;
			end else if (ch == CH_BS) begin
				if (col_at > 0)
					col_at--;
			end else if (ch == CH_TAB) begin
				col_at += TAB_STOP - (col_at % TAB_STOP);
			end else if (ch == CH_LF) begin
				line_end();
			end else if (ch == CH_FF) begin
				if (en)
					foreach (cells[i])
						cells[i] = attr_cell(8'd0);
				row_at = 0;
				col_at = 0;
				clears++;
			end else if (ch == CH_CR) begin
				col_at = 0;
			end
			if (col_at >= COLUMNS)
				line_end();
		endfunction

		function void take_item(console_item_t it);
			console_beat_t b;
			b.cell_data = '0;
			if (it.operation == OP_CHAR) begin
				apply_char(it.char_byte);
			end else begin
				reads++;
				if (it.read_row < ROWS && it.read_col < COLUMNS)
					b.cell_data = cells[it.read_row * COLUMNS + it.read_col];
			end
			b.cursor_row = OROW_W'(row_at);
			b.cursor_col = OCOL_W'(col_at);
			b.cursor_position = OPOS_W'(col_at + row_at * COLUMNS);
			cursor_cell_q.push_back(b);
		endfunction

		task report_mismatch(string msg);
			failures++;
			if (failures <= 40)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		task check_beat(console_beat_t got);
			console_beat_t want;
			beats_seen++;
			if (cursor_cell_q.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing pending", beats_seen));
			end else begin
				want = cursor_cell_q.pop_front();
				if (got.cell_data !== want.cell_data)
					report_mismatch($sformatf("beat %0d cell_data got %h want %h",
						beats_seen, got.cell_data, want.cell_data));
				if (got.cursor_row !== want.cursor_row)
					report_mismatch($sformatf("beat %0d cursor_row got %0d want %0d",
						beats_seen, got.cursor_row, want.cursor_row));
				if (got.cursor_col !== want.cursor_col)
					report_mismatch($sformatf("beat %0d cursor_col got %0d want %0d",
						beats_seen, got.cursor_col, want.cursor_col));
				if (got.cursor_position !== want.cursor_position)
					report_mismatch($sformatf("beat %0d cursor_position got %0d want %0d",
						beats_seen, got.cursor_position, want.cursor_position));
			end
		endtask

		task finish_check();
			if (cursor_cell_q.size() != 0)
				report_mismatch($sformatf("%0d result beats never arrived", cursor_cell_q.size()));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  operation;
	logic [CH_W-1:0]       char_byte;
	logic [RROW_W-1:0]     read_row;
	logic [RCOL_W-1:0]     read_col;
	logic                  out_valid;
	logic                  out_stall;
	logic [CELL_W-1:0]     cell_data;
	logic [OROW_W-1:0]     cursor_row;
	logic [OCOL_W-1:0]     cursor_col;
	logic [OPOS_W-1:0]     cursor_position;

	console_checker chk = new();
	int unsigned    items_sent;
	int unsigned    burst_left;
	int unsigned    cycles;
	int unsigned    held_back;
	int unsigned    long_holds;
	int unsigned    phases_run;
	bit             hold_req;

	text_console_char_engine u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.char_byte       (char_byte),
		.read_row        (read_row),
		.read_col        (read_col),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_data       (cell_data),
		.cursor_row      (cursor_row),
		.cursor_col      (cursor_col),
		.cursor_position (cursor_position)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// receiver: changing stall pattern, plus a long hold-off on request
	initial begin : receiver
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned mode;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
				long_holds++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= (cycles[2:0] == 3'd5);
				endcase
			end
		end
	end

	initial begin : result_monitor
		console_beat_t got;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && in_valid && in_stall === 1'b1 && out_stall)
				held_back++;
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
				got.cell_data = cell_data;
				got.cursor_row = cursor_row;
				got.cursor_col = cursor_col;
				got.cursor_position = cursor_position;
				chk.check_beat(got);
			end
		end
	end

	function automatic console_item_t mk_char(logic [CH_W-1:0] ch);
		console_item_t it;
		it.operation = OP_CHAR;
		it.char_byte = ch;
		it.read_row = RROW_W'($urandom_range(0, 31));
		it.read_col = RCOL_W'($urandom_range(0, 127));
		return it;
	endfunction

	function automatic console_item_t mk_read(int unsigned r, int unsigned c);
		console_item_t it;
		it.operation = OP_READ;
		it.char_byte = CH_W'($urandom_range(0, 255));
		it.read_row = RROW_W'(r);
		it.read_col = RCOL_W'(c);
		return it;
	endfunction

	function automatic console_item_t rand_item();
		console_item_t it;
		int unsigned w;
		it = mk_char(CH_W'($urandom_range(0, 255)));
		w = $urandom_range(0, 999);
		if (w < 120) begin
			it.operation = OP_READ;
			if ($urandom_range(0, 5) != 0) begin
				it.read_row = RROW_W'($urandom_range(0, ROWS - 1));
				it.read_col = RCOL_W'($urandom_range(0, COLUMNS - 1));
			end
		end else if (w < 640) begin
			it.char_byte = CH_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
		end else if (w < 700) begin
			it.char_byte = CH_LF;
		end else if (w < 730) begin
			it.char_byte = CH_CR;
		end else if (w < 780) begin
			it.char_byte = CH_BS;
		end else if (w < 830) begin
			it.char_byte = CH_TAB;
		end else if (w < 836) begin
			it.char_byte = CH_FF;
		end
		return it;
	endfunction

	task automatic pace();
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_item(console_item_t it);
		bit taken;
		in_valid <= 1'b1;
		operation <= it.operation;
		char_byte <= it.char_byte;
		read_row <= it.read_row;
		read_col <= it.read_col;
		do begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		chk.take_item(it);
		items_sent++;
		pace();
	endtask

	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		while (chk.cursor_cell_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(logic [3:0] fg, logic [2:0] bg, logic en);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEXT_COLOR;
		cfg_data <= fg;
		@(posedge clk);
		chk.set_register(CFG_TEXT_COLOR, fg);
		cfg_index <= CFG_BACK_COLOR;
		cfg_data <= {1'b0, bg};
		@(posedge clk);
		chk.set_register(CFG_BACK_COLOR, {1'b0, bg});
		cfg_index <= CFG_ENABLE;
		cfg_data <= {3'b000, en};
		@(posedge clk);
		chk.set_register(CFG_ENABLE, {3'b000, en});
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	task automatic run_random(int unsigned budget);
		int unsigned done;
		int unsigned seg;
		int unsigned n;
		done = 0;
		hold_req = 1'b1;
		while (done < budget) begin
			seg = $urandom_range(0, 9);
			if (seg < 6) begin
				n = $urandom_range(8, 40);
				if (n > budget - done)
					n = budget - done;
				repeat (n) send_item(rand_item());
			end else if (seg < 8) begin
				// long text run so lines wrap
				n = $urandom_range(60, 170);
				if (n > budget - done)
					n = budget - done;
				repeat (n) begin
					if ($urandom_range(0, 11) == 0)
						send_item(mk_read(chk.row_at, $urandom_range(0, COLUMNS - 1)));
					else
						send_item(mk_char(CH_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI))));
				end
			end else begin
				n = $urandom_range(4, 16);
				if (n > budget - done)
					n = budget - done;
				repeat (n) begin
					if ($urandom_range(0, 1) == 0)
						send_item(mk_read(chk.row_at, $urandom_range(0, COLUMNS - 1)));
					else
						send_item(mk_read($urandom_range(0, ROWS - 1),
							$urandom_range(0, COLUMNS - 1)));
				end
			end
			done += n;
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TEXT_COLOR;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_CHAR;
		char_byte <= '0;
		read_row <= '0;
		read_col <= '0;
		hold_req = 1'b0;
		items_sent = 0;
		burst_left = 0;
		held_back = 0;
		long_holds = 0;
		phases_run = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats on reset settings
		send_item(mk_read(0, 0));
		send_item(mk_read(31, 127));
		send_item(mk_char(CH_PRINT_LO));
		send_item(mk_char(CH_PRINT_HI));
		send_item(mk_char(8'd65));
		send_item(mk_char(8'd0));
		send_item(mk_char(8'd255));
		send_item(mk_char(8'd127));
		send_item(mk_char(8'd31));
		send_item(mk_read(0, 0));
		send_item(mk_read(0, 1));
		send_item(mk_read(ROWS - 1, COLUMNS - 1));
		send_item(mk_read(ROWS, 0));
		send_item(mk_read(0, COLUMNS));
		send_item(mk_char(CH_BS));
		send_item(mk_char(CH_TAB));
		send_item(mk_char(CH_TAB));
		send_item(mk_char(CH_CR));
		send_item(mk_char(CH_BS));
		send_item(mk_char(CH_LF));
		send_item(mk_char(8'd122));
		send_item(mk_char(CH_FF));
		send_item(mk_read(1, 0));
		send_item(mk_read(0, 2));
		run_random(170);

		for (int p = 1; p <= 6; p++) begin
			drain();
			case (p)
				1: write_config(4'd0, 3'd0, 1'b1);
				2: write_config(4'd15, 3'd7, 1'b0);
				3: write_config(4'd9, 3'd5, 1'b1);
				4: write_config(4'd0, 3'd7, 1'b1);
				5: write_config(4'd6, 3'd2, 1'b0);
				default: write_config(4'd15, 3'd7, 1'b1);
			endcase
			if (!chk.en) begin
				// reach the bottom row so line ends scroll with writes off, then a form feed homes the cursor
				repeat (ROWS) send_item(mk_char(CH_LF));
				send_item(mk_char(CH_FF));
			end
			run_random(170);
		end

		drain();
		repeat (50) @(posedge clk);
		chk.finish_check();
		$display("covered %0d beats (%0d cell reads), %0d scrolls, %0d clears, %0d setting changes",
			items_sent, chk.reads, chk.scrolls, chk.clears, phases_run);
		$display("input held back on %0d cycles under %0d long output hold-offs; %0d mismatches",
			held_back, long_holds, chk.failures);
		if (chk.failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
